/* rtl/core/tfrg_pkg.sv */
// Shared types, constants and size-step functions for the thermal/fps
// resolution governor. No dependencies; used by every block module except tfrg_div.
package tfrg_pkg;

    // Field widths
    localparam int SIZE_W   = 5;
    localparam int FPS_W    = 18;
    localparam int TEMP_W   = 12;
    localparam int TIME_W   = 32;
    localparam int IVAL_W   = 16;

    // Stream packing
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int IN_TS_LO    = 0;
    localparam int IN_SIZE_LO  = 32;
    localparam int IN_TEMP_LO  = 37;
    localparam int IN_TVAL_BIT = 49;
    localparam int IN_RACC_BIT = 50;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_DYN_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FPS = 3'd5;

    // Register reset values
    localparam logic [IVAL_W-1:0]        INTERVAL_RST = 16'd2000;
    localparam logic signed [TEMP_W-1:0] HOT_RST      = 12'sd1120;
    localparam logic signed [TEMP_W-1:0] COOL_RST     = 12'sd1040;
    localparam logic [FPS_W-1:0]         LOW_FPS_RST  = 18'd1280;
    localparam logic [FPS_W-1:0]         HIGH_FPS_RST = 18'd2048;

    localparam int MS_PER_S = 1000;
    localparam logic [FPS_W-1:0] FPS_MAX = 18'h3FFFF;

    // Frame size codes
    localparam logic [SIZE_W-1:0] SIZE_QVGA = 5'd5;
    localparam logic [SIZE_W-1:0] SIZE_VGA  = 5'd8;
    localparam logic [SIZE_W-1:0] SIZE_SVGA = 5'd9;
    localparam logic [SIZE_W-1:0] SIZE_XGA  = 5'd10;
    localparam logic [SIZE_W-1:0] SIZE_UXGA = 5'd13;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the accepted item
        logic div_start;  // launch the rate divider
        logic blend;      // fold the quotient into the smoothed rate
        logic commit;     // update state and load the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_rate;  // this item produces a new rate sample
        logic div_busy;
    } sts_t;

    // One size step down; codes at or below QVGA stay
    function automatic logic [SIZE_W-1:0] step_down(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] r;
        case (sz)
            SIZE_UXGA: r = SIZE_XGA;
            SIZE_XGA:  r = SIZE_SVGA;
            SIZE_SVGA: r = SIZE_VGA;
            default:   r = (sz > SIZE_QVGA) ? SIZE_QVGA : sz;
        endcase
        return r;
    endfunction

    // One size step up; codes at or above UXGA stay
    function automatic logic [SIZE_W-1:0] step_up(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] r;
        case (sz)
            SIZE_QVGA: r = SIZE_VGA;
            SIZE_VGA:  r = SIZE_SVGA;
            SIZE_SVGA: r = SIZE_XGA;
            default:   r = (sz < SIZE_UXGA) ? SIZE_UXGA : sz;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/tfrg_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Depends on nothing; instantiated by tfrg_dp.
module tfrg_div #(
    parameter int QW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [31:0]   divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   dsr_reg, dsr_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[31:0] : trial[31:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers, no reset needed
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/tfrg_dp.sv */
// Datapath: configuration registers, item latch, rate estimate, size decision
// and output register. Depends on tfrg_pkg and tfrg_div.
module tfrg_dp #(
    parameter int FPS_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [tfrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfrg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tuser,
    input  logic [tfrg_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  tfrg_pkg::cmd_t                      cmd,
    output tfrg_pkg::sts_t                      sts,
    output logic [tfrg_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int SIZE_W = tfrg_pkg::SIZE_W;
    localparam int FPS_W  = tfrg_pkg::FPS_W;
    localparam int TEMP_W = tfrg_pkg::TEMP_W;
    localparam int TIME_W = tfrg_pkg::TIME_W;
    localparam int IVAL_W = tfrg_pkg::IVAL_W;
    localparam longint DIVIDEND = longint'(tfrg_pkg::MS_PER_S) << FPS_FRAC_BITS;
    localparam int QW = $clog2(DIVIDEND + 1);
    localparam int SW = ((QW > FPS_W + 2) ? QW : FPS_W + 2) + 1;

    // Configuration registers
    logic                     dyn_en_reg;
    logic [IVAL_W-1:0]        interval_reg;
    logic signed [TEMP_W-1:0] hot_reg;
    logic signed [TEMP_W-1:0] cool_reg;
    logic [FPS_W-1:0]         low_fps_reg;
    logic [FPS_W-1:0]         high_fps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dyn_en_reg   <= 1'b0;
            interval_reg <= tfrg_pkg::INTERVAL_RST;
            hot_reg      <= tfrg_pkg::HOT_RST;
            cool_reg     <= tfrg_pkg::COOL_RST;
            low_fps_reg  <= tfrg_pkg::LOW_FPS_RST;
            high_fps_reg <= tfrg_pkg::HIGH_FPS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tfrg_pkg::REG_DYN_EN:   dyn_en_reg   <= cfg_data[0];
                tfrg_pkg::REG_INTERVAL: interval_reg <= cfg_data[IVAL_W-1:0];
                tfrg_pkg::REG_HOT:      hot_reg      <= $signed(cfg_data[TEMP_W-1:0]);
                tfrg_pkg::REG_COOL:     cool_reg     <= $signed(cfg_data[TEMP_W-1:0]);
                tfrg_pkg::REG_LOW_FPS:  low_fps_reg  <= cfg_data[FPS_W-1:0];
                tfrg_pkg::REG_HIGH_FPS: high_fps_reg <= cfg_data[FPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched item
    logic                     func_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [SIZE_W-1:0]        start_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     tval_reg;
    logic                     racc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            now_reg   <= s_tdata[tfrg_pkg::IN_TS_LO +: TIME_W];
            start_reg <= s_tdata[tfrg_pkg::IN_SIZE_LO +: SIZE_W];
            temp_reg  <= $signed(s_tdata[tfrg_pkg::IN_TEMP_LO +: TEMP_W]);
            tval_reg  <= s_tdata[tfrg_pkg::IN_TVAL_BIT];
            racc_reg  <= s_tdata[tfrg_pkg::IN_RACC_BIT];
        end
    end

    // Governor state
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [FPS_W-1:0]  fps_reg, fps_next;
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic              seen_reg, seen_next;
    logic [TIME_W-1:0] last_adapt_reg, last_adapt_next;
    logic              upd_reg, upd_next;

    // Output register
    logic [SIZE_W-1:0] out_size_reg, out_size_next;
    logic [FPS_W-1:0]  out_fps_reg, out_fps_next;
    logic              out_upd_reg, out_upd_next;
    logic              out_chg_reg, out_chg_next;

    // Rate divider: (1000 << frac) / gap
    logic [TIME_W-1:0] gap;
    logic [QW-1:0]     quotient;
    logic              div_busy;

    assign gap = now_reg - prev_time_reg;

    tfrg_div #(
        .QW (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (QW'(DIVIDEND)),
        .divisor  (gap),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign sts.need_rate = func_reg && seen_reg && (now_reg != prev_time_reg);
    assign sts.div_busy  = div_busy;

    // Blend 3/4 old plus 1/4 new, saturated; a zero old rate takes the new sample
    logic [SW-1:0] three_old;
    logic [SW-1:0] blend_sum;
    logic [SW-1:0] blended;
    logic [FPS_W-1:0] fps_sat;

    assign three_old = {{(SW-FPS_W-1){1'b0}}, fps_reg, 1'b0} + SW'(fps_reg);
    assign blend_sum = three_old + SW'(quotient);
    assign blended   = (fps_reg == '0) ? SW'(quotient) : (blend_sum >> 2);
    assign fps_sat   = (blended > SW'(tfrg_pkg::FPS_MAX)) ? tfrg_pkg::FPS_MAX
                                                          : blended[FPS_W-1:0];

    // Size decision
    logic [TIME_W-1:0] elapsed;
    logic              adapt_go;
    logic              go_down;
    logic              go_up;
    logic [SIZE_W-1:0] size_cand;

    assign elapsed  = now_reg - last_adapt_reg;
    assign adapt_go = dyn_en_reg && (elapsed >= TIME_W'(interval_reg));
    assign go_down  = !tval_reg || (temp_reg >= hot_reg) || (fps_reg < low_fps_reg);
    assign go_up    = tval_reg && (temp_reg < cool_reg) && (fps_reg >= high_fps_reg);

    always_comb begin
        if (go_down && size_reg > tfrg_pkg::SIZE_QVGA) begin
            size_cand = tfrg_pkg::step_down(size_reg);
        end else if (go_up && size_reg < tfrg_pkg::SIZE_UXGA) begin
            size_cand = tfrg_pkg::step_up(size_reg);
        end else begin
            size_cand = size_reg;
        end
    end

    // State and output update
    always_comb begin
        size_next       = size_reg;
        fps_next        = fps_reg;
        prev_time_next  = prev_time_reg;
        seen_next       = seen_reg;
        last_adapt_next = last_adapt_reg;
        upd_next        = upd_reg;
        out_size_next   = out_size_reg;
        out_fps_next    = out_fps_reg;
        out_upd_next    = out_upd_reg;
        out_chg_next    = out_chg_reg;
        if (cmd.load) begin
            upd_next = 1'b0;
        end
        if (cmd.blend) begin
            fps_next = fps_sat;
            upd_next = 1'b1;
        end
        if (cmd.commit) begin
            out_chg_next = 1'b0;
            if (!func_reg) begin
                // stream start
                size_next       = start_reg;
                fps_next        = '0;
                seen_next       = 1'b0;
                last_adapt_next = now_reg;
            end else begin
                prev_time_next = now_reg;
                seen_next      = 1'b1;
                if (adapt_go) begin
                    last_adapt_next = now_reg;
                    if (size_cand != size_reg && racc_reg) begin
                        size_next    = size_cand;
                        out_chg_next = 1'b1;
                    end
                end
            end
            out_size_next = size_next;
            out_fps_next  = fps_next;
            out_upd_next  = func_reg && upd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg       <= '0;
            fps_reg        <= '0;
            prev_time_reg  <= '0;
            seen_reg       <= 1'b0;
            last_adapt_reg <= '0;
        end else begin
            size_reg       <= size_next;
            fps_reg        <= fps_next;
            prev_time_reg  <= prev_time_next;
            seen_reg       <= seen_next;
            last_adapt_reg <= last_adapt_next;
        end
    end

    always_ff @(posedge aclk) begin
        upd_reg      <= upd_next;
        out_size_reg <= out_size_next;
        out_fps_reg  <= out_fps_next;
        out_upd_reg  <= out_upd_next;
        out_chg_reg  <= out_chg_next;
    end

    assign m_tdata = {{(tfrg_pkg::OUT_TDATA_W - SIZE_W - FPS_W - 2){1'b0}},
                      out_chg_reg, out_upd_reg, out_fps_reg, out_size_reg};

endmodule

/* rtl/core/tfrg_ctrl.sv */
// Controller state machine: sequences accept, divide, blend and commit, and
// owns both stream handshakes. Depends on tfrg_pkg.
module tfrg_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  tfrg_pkg::sts_t sts,
    output tfrg_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_ADAPT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (sts.need_rate) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_ADAPT;
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    cmd.blend  = 1'b1;
                    state_next = ST_ADAPT;
                end
            end
            ST_ADAPT: begin
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Divider is only ever running while the rate step is in progress
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_CALC) |-> !sts.div_busy)
        else $error("divider busy outside the rate step");

    // An accepted transaction always proceeds to evaluation
    a_accept_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CALC))
        else $error("accepted transaction not evaluated");

    // Divider launched only for a real rate sample
    a_div_need: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.need_rate)
        else $error("divider started without a rate sample");

    // Commit always presents a result on the next cycle
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

endmodule

/* rtl/core/thermal_fps_resolution_governor_top.sv */
// Top level of the thermal/fps resolution governor: controller plus datapath.
// Depends on tfrg_pkg, tfrg_ctrl, tfrg_dp (and tfrg_div below it).
//
// One transaction in, one result out. A start transaction (s_tuser 0), or a frame
// transaction without a new rate sample, goes from acceptance through evaluation
// to commit, where its result is registered for the output. A frame that yields a
// rate sample runs the bit-serial restoring divider for (1000 << FPS_FRAC_BITS) / gap,
// one quotient bit per cycle over a QW-bit quotient, between evaluation and commit,
// QW being the bit width of 1000 << FPS_FRAC_BITS (18 at the default). Commit waits
// while a previous result still waits on m_tready; the next transaction is taken
// once the commit is done.
// One transaction is processed at a time; the result register lets a new
// transaction be accepted while the previous result still waits on m_tready.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while idle; unknown indexes are ignored.
module thermal_fps_resolution_governor_top #(
    parameter int FPS_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tfrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfrg_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,  // func
    // timestamp_ms[31:0], start_size[36:32], temp_q4[48:37],
    // temp_valid[49], resize_accepted[50], zero fill [55:51]
    input  logic [tfrg_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame_size[4:0], fps_q8[22:5], fps_updated[23], size_changed[24],
    // zero fill [31:25]
    output logic [tfrg_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    tfrg_pkg::cmd_t cmd;
    tfrg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tfrg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tfrg_dp #(
        .FPS_FRAC_BITS (FPS_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

/* sim/tfrg_governor_checker.sv */
// Checker for the thermal/fps resolution governor: watches the register,
// input and result channels, predicts each result and compares it.
// Depends on tfrg_pkg for widths, stream packing, register indexes and size codes.
module tfrg_governor_checker #(
    parameter int FPS_FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tfrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfrg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             s_tuser,
    input  logic [tfrg_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tfrg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               pending,
    output int                               fail_count,
    output int                               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_W = tfrg_pkg::SIZE_W;
    localparam int FPS_W  = tfrg_pkg::FPS_W;
    localparam int TEMP_W = tfrg_pkg::TEMP_W;
    localparam int TIME_W = tfrg_pkg::TIME_W;
    localparam int IVAL_W = tfrg_pkg::IVAL_W;

    // result word layout, lowest bit up
    localparam int OUT_FPS_LO  = SIZE_W;
    localparam int OUT_UPD_BIT = SIZE_W + FPS_W;
    localparam int OUT_CHG_BIT = SIZE_W + FPS_W + 1;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_size;
        logic [FPS_W-1:0]  fps_q8;
        logic              fps_updated;
        logic              size_changed;
    } governor_result_t;

    governor_result_t expected_results[$];

    // register copy
    logic                     cfg_enable;
    logic [IVAL_W-1:0]        cfg_interval;
    logic signed [TEMP_W-1:0] cfg_hot;
    logic signed [TEMP_W-1:0] cfg_cool;
    logic [FPS_W-1:0]         cfg_low_fps;
    logic [FPS_W-1:0]         cfg_high_fps;

    // governor state copy
    logic [SIZE_W-1:0] cur_size;
    logic [FPS_W-1:0]  cur_fps;
    logic [TIME_W-1:0] prev_stamp;
    logic              prev_seen;
    logic [TIME_W-1:0] adapt_stamp;

    int err_tally     = 0;
    int checked_tally = 0;

    // Advance the governor state by one transaction and form its result
    task automatic predict_governor_result(input logic func,
                                           input logic [tfrg_pkg::IN_TDATA_W-1:0] word,
                                           output governor_result_t res);
        logic [TIME_W-1:0]        now;
        logic [TIME_W-1:0]        gap;
        logic [TIME_W-1:0]        since_adapt;
        logic [SIZE_W-1:0]        start_code;
        logic [SIZE_W-1:0]        target;
        logic signed [TEMP_W-1:0] temp;
        logic                     temp_ok;
        logic                     accept;
        logic                     go_down;
        logic                     go_up;
        logic [63:0]              rate;
        logic [63:0]              mixed;

        now        = word[tfrg_pkg::IN_TS_LO +: TIME_W];
        start_code = word[tfrg_pkg::IN_SIZE_LO +: SIZE_W];
        temp       = word[tfrg_pkg::IN_TEMP_LO +: TEMP_W];
        temp_ok    = word[tfrg_pkg::IN_TVAL_BIT];
        accept     = word[tfrg_pkg::IN_RACC_BIT];
        res        = '0;

        if (!func) begin
            // stream start: load size, clear the rate, restart the adaptation clock
            cur_size    = start_code;
            cur_fps     = '0;
            prev_seen   = 1'b0;
            adapt_stamp = now;
        end else begin
            // rate sample only with a previous frame and a non-zero gap
            if (prev_seen && now != prev_stamp) begin
                gap   = now - prev_stamp;
                rate  = (64'd1000 << FPS_FRAC_BITS) / {32'd0, gap};
                mixed = (cur_fps == '0) ? rate : ((64'(cur_fps) * 3) + rate) >> 2;
                cur_fps = (mixed > 64'(tfrg_pkg::FPS_MAX)) ? tfrg_pkg::FPS_MAX
                                                           : mixed[FPS_W-1:0];
                res.fps_updated = 1'b1;
            end
            prev_stamp = now;
            prev_seen  = 1'b1;

            // adaptation decision once per interval
            since_adapt = now - adapt_stamp;
            if (cfg_enable && since_adapt >= {16'd0, cfg_interval}) begin
                go_down = !temp_ok || temp >= cfg_hot || cur_fps < cfg_low_fps;
                go_up   = temp_ok && temp < cfg_cool && cur_fps >= cfg_high_fps;
                target  = cur_size;
                if (go_down && cur_size > tfrg_pkg::SIZE_QVGA) begin
                    case (cur_size)
                        tfrg_pkg::SIZE_UXGA: target = tfrg_pkg::SIZE_XGA;
                        tfrg_pkg::SIZE_XGA:  target = tfrg_pkg::SIZE_SVGA;
                        tfrg_pkg::SIZE_SVGA: target = tfrg_pkg::SIZE_VGA;
                        default:             target = tfrg_pkg::SIZE_QVGA;
                    endcase
                end else if (go_up && cur_size < tfrg_pkg::SIZE_UXGA) begin
                    case (cur_size)
                        tfrg_pkg::SIZE_QVGA: target = tfrg_pkg::SIZE_VGA;
                        tfrg_pkg::SIZE_VGA:  target = tfrg_pkg::SIZE_SVGA;
                        tfrg_pkg::SIZE_SVGA: target = tfrg_pkg::SIZE_XGA;
                        default:             target = tfrg_pkg::SIZE_UXGA;
                    endcase
                end
                if (target != cur_size && accept) begin
                    cur_size         = target;
                    res.size_changed = 1'b1;
                end
                adapt_stamp = now;
            end
        end
        res.frame_size = cur_size;
        res.fps_q8     = cur_fps;
    endtask

    // Channel monitor: register writes, input transactions, result transactions
    always @(posedge aclk) begin : monitor
        governor_result_t fresh;
        governor_result_t oldest;
        governor_result_t got;

        if (!aresetn) begin
            cfg_enable   = 1'b0;
            cfg_interval = tfrg_pkg::INTERVAL_RST;
            cfg_hot      = tfrg_pkg::HOT_RST;
            cfg_cool     = tfrg_pkg::COOL_RST;
            cfg_low_fps  = tfrg_pkg::LOW_FPS_RST;
            cfg_high_fps = tfrg_pkg::HIGH_FPS_RST;
            cur_size     = '0;
            cur_fps      = '0;
            prev_stamp   = '0;
            prev_seen    = 1'b0;
            adapt_stamp  = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tfrg_pkg::REG_DYN_EN:   cfg_enable   = cfg_data[0];
                    tfrg_pkg::REG_INTERVAL: cfg_interval = cfg_data[IVAL_W-1:0];
                    tfrg_pkg::REG_HOT:      cfg_hot      = cfg_data[TEMP_W-1:0];
                    tfrg_pkg::REG_COOL:     cfg_cool     = cfg_data[TEMP_W-1:0];
                    tfrg_pkg::REG_LOW_FPS:  cfg_low_fps  = cfg_data[FPS_W-1:0];
                    tfrg_pkg::REG_HIGH_FPS: cfg_high_fps = cfg_data[FPS_W-1:0];
                    default: ; // spare indexes have no effect
                endcase
            end

            if (s_tvalid && s_tready) begin
                predict_governor_result(s_tuser, s_tdata, fresh);
                expected_results.push_back(fresh);
            end

            if (m_tvalid && m_tready) begin
                got.frame_size   = m_tdata[SIZE_W-1:0];
                got.fps_q8       = m_tdata[OUT_FPS_LO +: FPS_W];
                got.fps_updated  = m_tdata[OUT_UPD_BIT];
                got.size_changed = m_tdata[OUT_CHG_BIT];
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing outstanding: tdata %h", m_tdata);
                    err_tally++;
                end else begin
                    oldest = expected_results.pop_front();
                    checked_tally++;
                    if (got.frame_size !== oldest.frame_size) begin
                        $error("frame_size: expected %0d, got %0d",
                               oldest.frame_size, got.frame_size);
                        err_tally++;
                    end
                    if (got.fps_q8 !== oldest.fps_q8) begin
                        $error("fps_q8: expected %0d, got %0d", oldest.fps_q8, got.fps_q8);
                        err_tally++;
                    end
                    if (got.fps_updated !== oldest.fps_updated) begin
                        $error("fps_updated: expected %0b, got %0b",
                               oldest.fps_updated, got.fps_updated);
                        err_tally++;
                    end
                    if (got.size_changed !== oldest.size_changed) begin
                        $error("size_changed: expected %0b, got %0b",
                               oldest.size_changed, got.size_changed);
                        err_tally++;
                    end
                end
            end
        end
        pending    <= expected_results.size();
        fail_count <= err_tally;
        checked    <= checked_tally;
    end

endmodule

/* sim/thermal_fps_resolution_governor_top_tb.sv */
// Testbench top for the thermal/fps resolution governor: clock, reset,
// register settings and stream stimulus. Depends on tfrg_pkg, the block and
// tfrg_governor_checker, which predicts and compares every result.
module thermal_fps_resolution_governor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 8;
    localparam int CFG_IDX_W  = tfrg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tfrg_pkg::CFG_DATA_W;
    localparam int SIZE_W     = tfrg_pkg::SIZE_W;
    localparam int FPS_W      = tfrg_pkg::FPS_W;
    localparam int TEMP_W     = tfrg_pkg::TEMP_W;
    localparam int TIME_W     = tfrg_pkg::TIME_W;
    localparam int IVAL_W     = tfrg_pkg::IVAL_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [CFG_IDX_W-1:0]             cfg_index;
    logic [CFG_DATA_W-1:0]            cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic                             s_tuser;
    logic [tfrg_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b1;
    logic [tfrg_pkg::OUT_TDATA_W-1:0] m_tdata;

    int chk_pending;
    int chk_fails;
    int chk_checked;

    int   items_sent    = 0;
    int   settings_used = 0;
    int   stall_left    = 0;
    logic s_idle_on     = 1'b0;
    logic m_idle_on     = 1'b0;
    logic quiet         = 1'b0;
    logic [TEMP_W-1:0] cur_hot  = tfrg_pkg::HOT_RST;
    logic [TEMP_W-1:0] cur_cool = tfrg_pkg::COOL_RST;

    thermal_fps_resolution_governor_top #(
        .FPS_FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tfrg_governor_checker #(
        .FPS_FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (chk_pending),
        .fail_count (chk_fails),
        .checked    (chk_checked)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result-side back-pressure in bursts of random length
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (m_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Temperatures clustered around the current limits, some anywhere
    function automatic logic [TEMP_W-1:0] pick_temp();
        case ($urandom_range(0, 7))
            0:       return TEMP_W'($urandom);
            1, 2, 3: return cur_hot + TEMP_W'($urandom_range(0, 32)) - 12'd16;
            default: return cur_cool + TEMP_W'($urandom_range(0, 32)) - 12'd16;
        endcase
    endfunction

    // One input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic func, input logic [TIME_W-1:0] ts,
                             input logic [SIZE_W-1:0] size, input logic [TEMP_W-1:0] temp,
                             input logic temp_ok, input logic accept);
        logic [tfrg_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[tfrg_pkg::IN_TS_LO +: TIME_W]   = ts;
        word[tfrg_pkg::IN_SIZE_LO +: SIZE_W] = size;
        word[tfrg_pkg::IN_TEMP_LO +: TEMP_W] = temp;
        word[tfrg_pkg::IN_TVAL_BIT]          = temp_ok;
        word[tfrg_pkg::IN_RACC_BIT]          = accept;
        if (s_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Full register set, written only once the block has gone idle;
    // unused upper data bits carry noise
    task automatic apply_settings(input logic en, input logic [IVAL_W-1:0] ival,
                                  input logic [TEMP_W-1:0] hot, input logic [TEMP_W-1:0] cool,
                                  input logic [FPS_W-1:0] low, input logic [FPS_W-1:0] high);
        wait_results();
        write_reg(tfrg_pkg::REG_DYN_EN,   {17'($urandom), en});
        write_reg(tfrg_pkg::REG_INTERVAL, {2'($urandom), ival});
        write_reg(tfrg_pkg::REG_HOT,      {6'($urandom), hot});
        write_reg(tfrg_pkg::REG_COOL,     {6'($urandom), cool});
        write_reg(tfrg_pkg::REG_LOW_FPS,  low);
        write_reg(tfrg_pkg::REG_HIGH_FPS, high);
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_hot  = hot;
        cur_cool = cool;
        settings_used++;
    endtask

    // A start transaction followed by frames at plausible gaps, with some noise
    task automatic run_stream(input int n_frames);
        logic [TIME_W-1:0] ts;
        logic [SIZE_W-1:0] size;
        int                gap_pick;

        s_idle_on = ($urandom_range(0, 3) != 0);
        m_idle_on = ($urandom_range(0, 3) != 0);
        ts = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 600) : $urandom;
        case ($urandom_range(0, 7))
            0, 1:    size = SIZE_W'($urandom);
            2:       size = tfrg_pkg::SIZE_QVGA;
            3:       size = tfrg_pkg::SIZE_VGA;
            4:       size = tfrg_pkg::SIZE_SVGA;
            5:       size = tfrg_pkg::SIZE_XGA;
            default: size = tfrg_pkg::SIZE_UXGA;
        endcase
        send_item(1'b0, ts, size, pick_temp(), 1'($urandom), 1'($urandom));

        for (int k = 0; k < n_frames; k++) begin
            if ($urandom_range(0, 59) == 0)
                wait_results();
            if ($urandom_range(0, 24) == 0) begin
                // noise: anything at all
                send_item(1'($urandom), $urandom, SIZE_W'($urandom), TEMP_W'($urandom),
                          1'($urandom), 1'($urandom));
            end else begin
                gap_pick = $urandom_range(0, 31);
                if (gap_pick < 2)
                    ts = ts;                          // repeated stamp
                else if (gap_pick == 2)
                    ts = ts + $urandom;               // long jump
                else if (gap_pick < 16)
                    ts = ts + $urandom_range(1, 60);  // fast
                else
                    ts = ts + $urandom_range(100, 320); // around the rate limits
                send_item(1'b1, ts, SIZE_W'($urandom), pick_temp(),
                          $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [IVAL_W-1:0] ival;
        logic [TEMP_W-1:0] hot;
        logic [FPS_W-1:0]  low;
        int                target;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values, adaptation off
        run_stream(10);

        // directed: decision on every frame, default limits
        apply_settings(1'b1, 16'd0, tfrg_pkg::HOT_RST, tfrg_pkg::COOL_RST,
                       tfrg_pkg::LOW_FPS_RST, tfrg_pkg::HIGH_FPS_RST);
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        send_item(1'b0, 32'd0, tfrg_pkg::SIZE_UXGA, 12'd0, 1'b1, 1'b1); // largest size
        send_item(1'b1, 32'd0, '0, 12'd0, 1'b1, 1'b1);          // first frame, zero rate
        send_item(1'b1, 32'd1, '1, 12'd0, 1'b1, 1'b1);          // 1 ms gap, fastest rate
        send_item(1'b1, 32'd1, '0, 12'd0, 1'b1, 1'b1);          // repeated stamp
        send_item(1'b1, 32'd2, '0, 12'h7FF, 1'b1, 1'b1);        // hottest reading
        send_item(1'b1, 32'd3, '0, 12'd0, 1'b0, 1'b0);          // invalid reading, refused
        send_item(1'b1, 32'd4, '0, 12'd0, 1'b0, 1'b1);          // invalid reading, taken
        send_item(1'b1, 32'd5, '0, tfrg_pkg::HOT_RST, 1'b1, 1'b1); // exactly at the hot limit
        send_item(1'b1, 32'd6, '0, tfrg_pkg::COOL_RST - 12'd1, 1'b1, 1'b1); // under cool limit
        send_item(1'b1, 32'd7, '0, tfrg_pkg::COOL_RST, 1'b1, 1'b1); // at the cool limit
        send_item(1'b0, 32'hFFFF_FFF0, 5'd31, 12'h800, 1'b1, 1'b1); // top code, coldest
        send_item(1'b1, 32'hFFFF_FFFF, '0, 12'h800, 1'b1, 1'b1);
        send_item(1'b1, 32'd5, '0, 12'h800, 1'b1, 1'b1);        // stamp wraps through zero
        send_item(1'b1, 32'd6, '0, 12'h800, 1'b1, 1'b1);
        send_item(1'b0, 32'd1000, 5'd0, 12'd0, 1'b0, 1'b0);     // code zero
        send_item(1'b1, 32'd1001, '0, 12'd0, 1'b1, 1'b1);
        send_item(1'b1, 32'd1000, '0, 12'd0, 1'b1, 1'b1);       // widest gap, rate zero
        send_item(1'b1, 32'd1003, '0, 12'd0, 1'b1, 1'b1);
        send_item(1'b1, 32'd2003, '0, 12'd0, 1'b1, 1'b1);       // slow frame blended in
        send_item(1'b0, 32'd5000, tfrg_pkg::SIZE_SVGA, 12'd0, 1'b1, 1'b1);
        send_item(1'b1, 32'd5000, '0, 12'd0, 1'b1, 1'b1);
        send_item(1'b1, 32'd5300, '0, 12'd0, 1'b1, 1'b1);       // below the low rate
        send_item(1'b1, 32'd5301, '0, 12'd0, 1'b1, 1'b1);
        send_item(1'b0, 32'd7000, 5'd11, 12'd0, 1'b1, 1'b1);    // code between XGA and UXGA
        send_item(1'b1, 32'd7001, '0, 12'd0, 1'b1, 1'b1);
        send_item(1'b1, 32'd7002, '0, 12'd0, 1'b1, 1'b1);

        // extreme settings
        apply_settings(1'b1, 16'd0, 12'h800, 12'h800, '0, '0);
        run_stream(30);
        apply_settings(1'b1, 16'hFFFF, 12'h7FF, 12'h7FF, tfrg_pkg::FPS_MAX, tfrg_pkg::FPS_MAX);
        run_stream(30);
        apply_settings(1'b1, 16'd0, 12'h7FF, 12'h800, tfrg_pkg::FPS_MAX, '0);
        run_stream(30);

        // random settings; the last phase runs without idling
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 4))
                0:       ival = '0;
                1:       ival = IVAL_W'($urandom_range(1, 300));
                2:       ival = tfrg_pkg::INTERVAL_RST;
                3:       ival = '1;
                default: ival = IVAL_W'($urandom);
            endcase
            hot = ($urandom_range(0, 3) == 0) ? TEMP_W'($urandom)
                                              : TEMP_W'($urandom_range(0, 2640)) - 12'd640;
            low = ($urandom_range(0, 3) == 0) ? FPS_W'($urandom)
                                              : FPS_W'($urandom_range(256, 4096));
            apply_settings($urandom_range(0, 4) != 0, ival, hot,
                           hot - TEMP_W'($urandom_range(0, 200)), low,
                           low + FPS_W'($urandom_range(0, 4096)));
            quiet  = (p == 9);
            target = items_sent + 88;
            while (items_sent < target)
                run_stream($urandom_range(4, 40));
        end

        // drain, then let any stray result show
        wait_results();
        repeat (40) @(posedge aclk);

        $display("%0d transactions sent and %0d results checked over %0d register settings,",
                 items_sent, chk_checked, settings_used);
        $display("covering limit extremes, stamp wrap, repeated stamps and refused resizes");
        if (chk_pending != 0)
            $error("%0d results never arrived", chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("thermal_fps_resolution_governor_top regression: pass");
        end else begin
            $display("thermal_fps_resolution_governor_top regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8_000_000);
        $display("thermal_fps_resolution_governor_top regression: fail");
        $finish;
    end

endmodule
